/* hw/rtl/pab_pkg.sv */
// Package for the particle advection block: shared constants, types and the
// Q16.16 helper functions. No dependencies.
package pab_pkg;

  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ONE_Q16    = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_Y_MIN  = 3'd1,
    REG_X_MAX  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_DT     = 3'd4,
    REG_INV_DX = 3'd5,
    REG_INV_DY = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_GRID   = 1'b0,
    REQ_ADVECT = 1'b1
  } req_type_t;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  node_col;
    logic [5:0]  node_row;
    logic signed [31:0] node_u;
    logic signed [31:0] node_v;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_u_in;
    logic signed [31:0] vel_v_in;
    logic        is_active;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_u;
    logic signed [31:0] new_v;
    logic        still_active;
    logic        last_out;
  } out_item_t;

  // Saturate a 49-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -49'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  // Q16.16 product of a 64-bit product, truncated toward zero.
  function automatic logic signed [47:0] qtrunc(input logic signed [63:0] p);
    logic signed [63:0] a;
    a = (p < 0) ? p + 64'sd65535 : p;
    return a[63:16];
  endfunction

endpackage

/* hw/rtl/pab_if.sv */
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing; payload types come from pab_pkg.
interface pab_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pab_cfg_if.sv */
// Configuration write channel: register index and data with valid/ready.
// Uses pab_pkg constants.
interface pab_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [pab_pkg::CFG_IDX_W-1:0]  index;
  logic [pab_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hw/rtl/particle_advect_bilinear.sv */
// Top level of the particle advection block: config registers, grid memory,
// advection pipeline and output skid. Depends on pab_pkg, pab_if, pab_cfg_if.
//
//  channel | dir | payload                 | role
//  in_*    | in  | pab_pkg::in_item_t      | grid writes and particles
//  out_*   | out | pab_pkg::out_item_t     | one result per particle
//  cfg_*   | in  | index, wdata            | register writes
//
// One item per cycle while the pipeline advances; a particle result passes the
// multiply stages and the grid memory read on its way to the output buffer.
// Grid writes give no result.
// Synchronous reset clears registers to their defaults; grid content is
// undefined until written. The pipeline holds only when both output buffer
// entries are taken and a result is due; input ready comes from registers.
module particle_advect_bilinear #(
  parameter int GRID_X = pab_pkg::GRID_X_DEF,
  parameter int GRID_Y = pab_pkg::GRID_Y_DEF
) (
  input logic clk,
  input logic rst_n,
  pab_if.sink       in_ch,
  pab_if.source     out_ch,
  pab_cfg_if.sink   cfg_ch
);
  logic signed [31:0] x_min_r, y_min_r, x_max_r, y_max_r, dt_r;
  logic [30:0] inv_dx_r, inv_dy_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0; y_min_r <= '0;
      x_max_r <= 32'sd65536; y_max_r <= 32'sd65536;
      dt_r <= '0; inv_dx_r <= 31'd65536; inv_dy_r <= 31'd65536;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pab_pkg::REG_X_MIN:  x_min_r  <= cfg_ch.wdata;
        pab_pkg::REG_Y_MIN:  y_min_r  <= cfg_ch.wdata;
        pab_pkg::REG_X_MAX:  x_max_r  <= cfg_ch.wdata;
        pab_pkg::REG_Y_MAX:  y_max_r  <= cfg_ch.wdata;
        pab_pkg::REG_DT:     dt_r     <= cfg_ch.wdata;
        pab_pkg::REG_INV_DX: inv_dx_r <= cfg_ch.wdata[30:0];
        pab_pkg::REG_INV_DY: inv_dy_r <= cfg_ch.wdata[30:0];
        default: ;
      endcase
    end
  end

  // output buffer of two entries
  pab_pkg::out_item_t buf_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic adv, pv, push, pop;
  logic [6:0] vld;
  pab_pkg::out_item_t po;

  // advance unless the buffer is full and a result is about to land
  assign adv  = !(cnt_r == 2'd2 && pv);
  assign push = adv && pv;
  assign pop  = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.data  = buf_r[rp_r];
  assign in_ch.ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
  always_ff @(posedge clk) if (push) buf_r[wp_r] <= po;

  logic acc, gw, go;
  assign acc = in_ch.valid && in_ch.ready;
  assign gw  = acc && in_ch.data.req_type == pab_pkg::REQ_GRID;
  assign go  = acc && in_ch.data.req_type == pab_pkg::REQ_ADVECT;

  logic rd_en;
  logic [pab_pkg::COORD_W-1:0] rd_col, rd_row;
  logic [63:0] rd_data [4];
  logic wr_ok;
  assign wr_ok = gw && 32'(in_ch.data.node_col) < GRID_X
                    && 32'(in_ch.data.node_row) < GRID_Y;

  pab_grid_mem #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_mem (
    .clk, .wr_en(wr_ok), .wr_col(in_ch.data.node_col),
    .wr_row(in_ch.data.node_row),
    .wr_data({in_ch.data.node_u, in_ch.data.node_v}),
    .rd_en, .rd_col, .rd_row, .rd_data
  );

  pab_pipe #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_pipe (
    .clk, .rst_n, .adv, .in_go(go), .in_item(in_ch.data),
    .x_min(x_min_r), .y_min(y_min_r), .x_max(x_max_r), .y_max(y_max_r),
    .dt(dt_r), .inv_dx(inv_dx_r), .inv_dy(inv_dy_r),
    .rd_en, .rd_col, .rd_row, .rd_data, .vld, .out_v(pv), .out_item(po)
  );

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("output buffer overflow");
  a_nopush_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full buffer");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld)) else $error("pipeline moved while stalled");
endmodule

/* hw/rtl/pab_grid_mem.sv */
// Parity-banked velocity grid: four banks by (row, col) parity, so any 2x2
// cell is read in one access; read data is registered. Depends on pab_pkg.
module pab_grid_mem #(
  parameter int GRID_X = pab_pkg::GRID_X_DEF,
  parameter int GRID_Y = pab_pkg::GRID_Y_DEF
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [pab_pkg::COORD_W-1:0] wr_col,
  input  logic [pab_pkg::COORD_W-1:0] wr_row,
  input  logic [63:0] wr_data,
  input  logic        rd_en,
  input  logic [pab_pkg::COORD_W-1:0] rd_col,
  input  logic [pab_pkg::COORD_W-1:0] rd_row,
  output logic [63:0] rd_data [4]
);
  localparam int HX = (GRID_X + 1) / 2;
  localparam int HY = (GRID_Y + 1) / 2;
  localparam int BD = HX * HY;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  logic [63:0] bank0 [BD];
  logic [63:0] bank1 [BD];
  logic [63:0] bank2 [BD];
  logic [63:0] bank3 [BD];

  logic [pab_pkg::COORD_W-1:0] wc_h, wr_h;
  logic [AW-1:0] waddr;
  logic [1:0]    wbank;
  assign wc_h  = wr_col >> 1;
  assign wr_h  = wr_row >> 1;
  assign waddr = AW'(wr_h * HX + wc_h);
  assign wbank = {wr_row[0], wr_col[0]};

  // corner a at col c+a row r+b lives in bank {(r+b)[0],(c+a)[0]}
  logic [pab_pkg::COORD_W:0] c1, r1;
  logic [AW-1:0] a_ee, a_eo, a_oe, a_oo;
  logic [pab_pkg::COORD_W-1:0] ce, co, re, ro;
  assign c1 = {1'b0, rd_col} + 1'b1;
  assign r1 = {1'b0, rd_row} + 1'b1;
  // even/odd column halves of the cell's two columns
  assign ce = rd_col[0] ? c1[pab_pkg::COORD_W:1] : rd_col >> 1;
  assign co = rd_col >> 1;
  assign re = rd_row[0] ? r1[pab_pkg::COORD_W:1] : rd_row >> 1;
  assign ro = rd_row >> 1;
  assign a_ee = AW'(re * HX + ce);
  assign a_eo = AW'(re * HX + co);
  assign a_oe = AW'(ro * HX + ce);
  assign a_oo = AW'(ro * HX + co);

  logic [63:0] q0_r, q1_r, q2_r, q3_r;
  logic [1:0]  par_r;

  always_ff @(posedge clk) begin
    if (wr_en && wbank == 2'd0) bank0[waddr] <= wr_data;
    if (wr_en && wbank == 2'd1) bank1[waddr] <= wr_data;
    if (wr_en && wbank == 2'd2) bank2[waddr] <= wr_data;
    if (wr_en && wbank == 2'd3) bank3[waddr] <= wr_data;
    if (rd_en) begin
      q0_r  <= bank0[a_ee];
      q1_r  <= bank1[a_eo];
      q2_r  <= bank2[a_oe];
      q3_r  <= bank3[a_oo];
      par_r <= {rd_row[0], rd_col[0]};
    end
  end

  // rd_data index = {b, a}: corner (col+a, row+b)
  always_comb begin
    logic [63:0] e0, e1, o0, o1;
    // row parity even row = banks 0/1, odd row = banks 2/3
    e0 = par_r[0] ? q1_r : q0_r;
    e1 = par_r[0] ? q0_r : q1_r;
    o0 = par_r[0] ? q3_r : q2_r;
    o1 = par_r[0] ? q2_r : q3_r;
    rd_data[0] = par_r[1] ? o0 : e0;
    rd_data[1] = par_r[1] ? o1 : e1;
    rd_data[2] = par_r[1] ? e0 : o0;
    rd_data[3] = par_r[1] ? e1 : o1;
  end
endmodule

/* hw/rtl/pab_pipe.sv */
// Advection datapath: locate, weights, bilinear sum, move, bounds check.
// Uses pab_pkg functions and the corner data from pab_grid_mem.
module pab_pipe #(
  parameter int GRID_X = pab_pkg::GRID_X_DEF,
  parameter int GRID_Y = pab_pkg::GRID_Y_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_go,
  input  pab_pkg::in_item_t in_item,
  input  logic signed [31:0] x_min,
  input  logic signed [31:0] y_min,
  input  logic signed [31:0] x_max,
  input  logic signed [31:0] y_max,
  input  logic signed [31:0] dt,
  input  logic [30:0] inv_dx,
  input  logic [30:0] inv_dy,
  output logic rd_en,
  output logic [pab_pkg::COORD_W-1:0] rd_col,
  output logic [pab_pkg::COORD_W-1:0] rd_row,
  input  logic [63:0] rd_data [4],
  output logic [6:0] vld,
  output logic out_v,
  output pab_pkg::out_item_t out_item
);
  localparam int NS = 7;

  // stage valid shift; advances whenever adv
  logic [NS-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_go};
  end
  assign vld   = v_r;
  assign out_v = v_r[NS-1];

  // S0: products (pos - min) * inv
  logic signed [32:0] dx0, dy0;
  assign dx0 = 33'(in_item.pos_x) - 33'(x_min);
  assign dy0 = 33'(in_item.pos_y) - 33'(y_min);
  logic signed [64:0] px1_r, py1_r;
  pab_pkg::in_item_t it1_r, it2_r, it3_r, it4_r, it5_r, it6_r, it7_r;
  always_ff @(posedge clk) if (adv) begin
    px1_r <= dx0 * $signed({1'b0, inv_dx});
    py1_r <= dy0 * $signed({1'b0, inv_dy});
    it1_r <= in_item;
  end

  // S1: index (truncate toward zero), fraction, range check, memory read
  logic signed [64:0] ix_full, iy_full;
  logic signed [64:0] rx, ry;
  logic signed [31:0] fx1, fy1;
  logic in_grid1;
  always_comb begin
    ix_full = px1_r >>> 32;
    iy_full = py1_r >>> 32;
    if (px1_r < 0 && px1_r[31:0] != '0) ix_full = ix_full + 65'sd1;
    if (py1_r < 0 && py1_r[31:0] != '0) iy_full = iy_full + 65'sd1;
    rx = px1_r - (ix_full <<< 32);
    ry = py1_r - (iy_full <<< 32);
    fx1 = 32'(pab_pkg::qtrunc(64'(rx)));
    fy1 = 32'(pab_pkg::qtrunc(64'(ry)));
    in_grid1 = ix_full >= 0 && ix_full < 65'(GRID_X - 1)
            && iy_full >= 0 && iy_full < 65'(GRID_Y - 1);
  end
  assign rd_en  = adv;
  assign rd_col = in_grid1 ? pab_pkg::COORD_W'(ix_full) : '0;
  assign rd_row = in_grid1 ? pab_pkg::COORD_W'(iy_full) : '0;

  logic signed [17:0] wx0_2r, wx1_2r, wy0_2r, wy1_2r;
  logic g2_r;
  always_ff @(posedge clk) if (adv) begin
    wx0_2r <= 18'(32'sd65536 - fx1);
    wx1_2r <= 18'(fx1);
    wy0_2r <= 18'(32'sd65536 - fy1);
    wy1_2r <= 18'(fy1);
    g2_r   <= in_grid1;
    it2_r  <= it1_r;
  end

  // S2: corner weights; memory data arrives here
  logic signed [35:0] wp [4];
  assign wp[0] = wx0_2r * wy0_2r;
  assign wp[1] = wx1_2r * wy0_2r;
  assign wp[2] = wx0_2r * wy1_2r;
  assign wp[3] = wx1_2r * wy1_2r;
  logic signed [18:0] w3_r [4];
  logic [63:0] nd3_r [4];
  logic g3_r;
  always_ff @(posedge clk) if (adv) begin
    for (int k = 0; k < 4; k++) begin
      w3_r[k]  <= 19'(pab_pkg::qtrunc(64'(wp[k])));
      nd3_r[k] <= rd_data[k];
    end
    g3_r  <= g2_r;
    it3_r <= it2_r;
  end

  // S3: weight * node terms
  logic signed [50:0] tu4_r [4], tv4_r [4];
  logic g4_r;
  always_ff @(posedge clk) if (adv) begin
    for (int k = 0; k < 4; k++) begin
      tu4_r[k] <= 51'(pab_pkg::qtrunc(64'(w3_r[k]) * 64'($signed(nd3_r[k][63:32]))));
      tv4_r[k] <= 51'(pab_pkg::qtrunc(64'(w3_r[k]) * 64'($signed(nd3_r[k][31:0]))));
    end
    g4_r  <= g3_r;
    it4_r <= it3_r;
  end

  // S4: sum and saturate
  logic signed [52:0] su, sv;
  assign su = 53'(tu4_r[0]) + 53'(tu4_r[1]) + 53'(tu4_r[2]) + 53'(tu4_r[3]);
  assign sv = 53'(tv4_r[0]) + 53'(tv4_r[1]) + 53'(tv4_r[2]) + 53'(tv4_r[3]);
  logic signed [31:0] u5_r, v5_r;
  logic g5_r;
  always_ff @(posedge clk) if (adv) begin
    u5_r <= (su > 53'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
            (su < -53'sh8000_0000) ? 32'sh8000_0000 : su[31:0];
    v5_r <= (sv > 53'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
            (sv < -53'sh8000_0000) ? 32'sh8000_0000 : sv[31:0];
    g5_r  <= g4_r;
    it5_r <= it4_r;
  end

  // S5: vel * dt
  logic signed [47:0] mu6_r, mv6_r;
  logic signed [31:0] u6_r, v6_r;
  logic g6_r;
  always_ff @(posedge clk) if (adv) begin
    mu6_r <= pab_pkg::qtrunc(u5_r * dt);
    mv6_r <= pab_pkg::qtrunc(v5_r * dt);
    u6_r  <= u5_r;
    v6_r  <= v5_r;
    g6_r  <= g5_r;
    it6_r <= it5_r;
  end

  // S6: new position saturated; |mu| < 2^47 so 49 bits hold the sum
  logic signed [31:0] nx7_r, ny7_r, u7_r, v7_r;
  logic g7_r;
  always_ff @(posedge clk) if (adv) begin
    nx7_r <= pab_pkg::sat49(49'(it6_r.pos_x) + 49'(mu6_r));
    ny7_r <= pab_pkg::sat49(49'(it6_r.pos_y) + 49'(mv6_r));
    u7_r  <= u6_r;
    v7_r  <= v6_r;
    g7_r  <= g6_r;
    it7_r <= it6_r;
  end

  // S7: select, bounds
  logic upd;
  assign upd = it7_r.is_active && g7_r;
  always_comb begin
    out_item.last_out = it7_r.last_in;
    if (upd) begin
      out_item.new_x = nx7_r;
      out_item.new_y = ny7_r;
      out_item.new_u = u7_r;
      out_item.new_v = v7_r;
      out_item.still_active = !(nx7_r < x_min || nx7_r > x_max
                                || ny7_r < y_min || ny7_r > y_max);
    end else begin
      out_item.new_x = it7_r.pos_x;
      out_item.new_y = it7_r.pos_y;
      out_item.new_u = it7_r.vel_u_in;
      out_item.new_v = it7_r.vel_v_in;
      out_item.still_active = 1'b0;
    end
  end
endmodule

/* sim/pab_advect_checker.sv */
// Checker for the particle advection block: watches the input, output and
// config channels, predicts each particle result and compares it.
// Depends on pab_pkg.
`timescale 1ns / 1ps
module pab_advect_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  pab_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  pab_pkg::out_item_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  output int   fail_count,
  output int   pending_results,
  output int   particle_count,
  output int   node_count
);
  localparam int GX = pab_pkg::GRID_X_DEF;
  localparam int GY = pab_pkg::GRID_Y_DEF;

  logic signed [31:0] u_field [GX*GY];
  logic signed [31:0] v_field [GX*GY];
  logic signed [31:0] x_lo, y_lo, x_hi, y_hi, step;
  logic [30:0] inv_x, inv_y;
  pab_pkg::out_item_t expected_q[$];
  int mismatch_count;

  assign pending_results = expected_q.size();

  // Q16.16 product truncated toward zero.
  function automatic longint qmul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pab_pkg::out_item_t advect(pab_pkg::in_item_t it);
    pab_pkg::out_item_t r;
    longint px, py, pu, pv, ix, iy, fx, fy, px64, py64, w, su, sv;
    longint wx[2], wy[2];
    int k;
    logic act;
    px = longint'(it.pos_x); py = longint'(it.pos_y);
    pu = longint'(it.vel_u_in); pv = longint'(it.vel_v_in);
    act = it.is_active;
    if (act) begin
      px64 = (px - longint'(x_lo)) * longint'({1'b0, inv_x});
      py64 = (py - longint'(y_lo)) * longint'({1'b0, inv_y});
      ix = px64 / (64'sd1 << 32);
      iy = py64 / (64'sd1 << 32);
      fx = (px64 - ix * (64'sd1 << 32)) / 65536;
      fy = (py64 - iy * (64'sd1 << 32)) / 65536;
      if (ix < 0 || ix >= GX - 1 || iy < 0 || iy >= GY - 1) begin
        act = 1'b0;
      end else begin
        wx[0] = 65536 - fx; wx[1] = fx;
        wy[0] = 65536 - fy; wy[1] = fy;
        su = 0; sv = 0;
        for (int b = 0; b < 2; b++)
          for (int a = 0; a < 2; a++) begin
            k = int'((iy + b) * GX + ix + a);
            w = qmul(wx[a], wy[b]);
            su += qmul(w, longint'(u_field[k]));
            sv += qmul(w, longint'(v_field[k]));
          end
        pu = sat32(su);
        pv = sat32(sv);
        px = sat32(px + qmul(pu, longint'(step)));
        py = sat32(py + qmul(pv, longint'(step)));
        if (px < x_lo || px > x_hi || py < y_lo || py > y_hi) act = 1'b0;
      end
    end
    r.new_x = px[31:0]; r.new_y = py[31:0];
    r.new_u = pu[31:0]; r.new_v = pv[31:0];
    r.still_active = act;
    r.last_out = it.last_in;
    return r;
  endfunction

  always @(posedge clk) begin
    pab_pkg::out_item_t exp_r;
    if (!rst_n) begin
      x_lo <= 0; y_lo <= 0; x_hi <= 65536; y_hi <= 65536; step <= 0;
      inv_x <= 65536; inv_y <= 65536;
      expected_q.delete();
      fail_count <= 0; mismatch_count = 0;
      particle_count <= 0; node_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pab_pkg::cfg_reg_t'(cfg_index))
          pab_pkg::REG_X_MIN:  x_lo <= cfg_wdata;
          pab_pkg::REG_Y_MIN:  y_lo <= cfg_wdata;
          pab_pkg::REG_X_MAX:  x_hi <= cfg_wdata;
          pab_pkg::REG_Y_MAX:  y_hi <= cfg_wdata;
          pab_pkg::REG_DT:     step <= cfg_wdata;
          pab_pkg::REG_INV_DX: inv_x <= cfg_wdata[30:0];
          pab_pkg::REG_INV_DY: inv_y <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == pab_pkg::REQ_GRID) begin
          u_field[in_data.node_row * GX + in_data.node_col] = in_data.node_u;
          v_field[in_data.node_row * GX + in_data.node_col] = in_data.node_v;
          node_count <= node_count + 1;
        end else begin
          expected_q.push_back(advect(in_data));
          particle_count <= particle_count + 1;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_data) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
      fail_count <= mismatch_count;
    end
  end
endmodule

/* sim/tb_particle_advect_bilinear.sv */
// Testbench top for particle_advect_bilinear: drives grid writes, particles
// and register writes; depends on pab_pkg, pab_if, pab_cfg_if, the checker.
`timescale 1ns / 1ps
module tb_particle_advect_bilinear;

  localparam int WATCHDOG = 20000;
  // nodes 0..FILL-1 on both axes are written; near random particles stay there
  localparam int FILL = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count, pending_results, particle_count, node_count;
  int send_idle_pct = 0, sink_stall_pct = 0;
  int quiet_cycles = 0;
  logic timed_out = 1'b0;
  logic signed [31:0] lo_x, lo_y;

  pab_if #(pab_pkg::in_item_t)  in_ch (clk);
  pab_if #(pab_pkg::out_item_t) out_ch (clk);
  pab_cfg_if                    cfg_ch (clk);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  particle_advect_bilinear DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pab_advect_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index), .cfg_wdata(cfg_ch.wdata),
    .fail_count(fail_count), .pending_results(pending_results),
    .particle_count(particle_count), .node_count(node_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
  end

  // receiver stalls at random
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready ||
        cfg_ch.valid && cfg_ch.ready || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out <= 1'b1;
      $display("watchdog expired, %0d results outstanding", pending_results);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // valid stays high after the transfer; set_box drops it
  task automatic write_reg(pab_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_box(logic signed [31:0] x0, logic signed [31:0] y0,
                         logic signed [31:0] x1, logic signed [31:0] y1,
                         logic signed [31:0] dt, logic [31:0] ix, logic [31:0] iy);
    write_reg(pab_pkg::REG_X_MIN, x0);
    write_reg(pab_pkg::REG_Y_MIN, y0);
    write_reg(pab_pkg::REG_X_MAX, x1);
    write_reg(pab_pkg::REG_Y_MAX, y1);
    write_reg(pab_pkg::REG_DT, dt);
    write_reg(pab_pkg::REG_INV_DX, ix);
    write_reg(pab_pkg::REG_INV_DY, iy);
    cfg_ch.valid <= 1'b0;
    lo_x = x0; lo_y = y0;
  endtask

  // one transfer on the input channel, with random idle before it;
  // valid stays high after the transfer, drain drops it
  task automatic send(pab_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_node(int col, int row, logic [31:0] u, logic [31:0] v);
    pab_pkg::in_item_t it;
    it = '0;
    it.req_type = pab_pkg::REQ_GRID;
    it.node_col = 6'(col); it.node_row = 6'(row);
    it.node_u = u; it.node_v = v;
    it.pos_x = $urandom(); it.pos_y = $urandom();
    send(it);
  endtask

  task automatic send_particle(logic [31:0] x, logic [31:0] y, logic act);
    pab_pkg::in_item_t it;
    it = '0;
    it.req_type = pab_pkg::REQ_ADVECT;
    it.node_col = 6'($urandom()); it.node_row = 6'($urandom());
    it.node_u = $urandom(); it.node_v = $urandom();
    it.pos_x = x; it.pos_y = y;
    it.vel_u_in = $urandom(); it.vel_v_in = $urandom();
    it.is_active = act;
    it.last_in = 1'($urandom_range(1));
    send(it);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($urandom_range(8 * 65536)) - 32'(4 * 65536);
    endcase
  endfunction

  // position in cells of the given size (1/inv)
  function automatic logic [31:0] rand_pos(logic signed [31:0] lo, int cell_q16);
    case ($urandom_range(9))
      0: return $urandom() | 32'h4000_0000;
      1: return lo - $urandom_range(65535);
      2: return lo + 63 * cell_q16 + $urandom_range(2 * cell_q16);
      default: return lo + $urandom_range((FILL - 1) * cell_q16 - 1);
    endcase
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_phase(int n, int cell_x, int cell_y);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 3)
        send_node($urandom_range(FILL - 1), $urandom_range(FILL - 1),
                  rand_vel(), rand_vel());
      else
        send_particle(rand_pos(lo_x, cell_x), rand_pos(lo_y, cell_y),
                      $urandom_range(9) != 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    lo_x = 0; lo_y = 0;
    // fill the low corner of the grid and three nodes of the top corner cell
    for (int r = 0; r < FILL; r++)
      for (int c = 0; c < FILL; c++)
        send_node(c, r, rand_vel(), rand_vel());
    send_node(62, 62, rand_vel(), rand_vel());
    send_node(63, 62, rand_vel(), rand_vel());
    send_node(62, 63, rand_vel(), rand_vel());
    // directed: edges of the fields, inactive, out of grid, zero reciprocal
    send_node(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_node(63, 63, 32'h8000_0000, 32'h7FFF_FFFF);
    send_particle(32'h0000_8000, 32'h0000_8000, 1'b1);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_particle(-32'sd100, 32'h0000_4000, 1'b1);
    send_particle(32'd62 << 16, 32'd62 << 16, 1'b1);
    send_particle(32'd63 << 16, 32'h0000_1000, 1'b1);
    send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain();
    set_box(32'sh0, 32'sh0, 32'd64 << 16, 32'd64 << 16, 32'h0000_4000, 0, 0);
    send_particle(32'h0010_0000, 32'h0020_0000, 1'b1);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    drain();
    // extreme registers with saturating step
    set_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_particle(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_particle(32'h8000_0100, 32'h8000_0200, 1'b1);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    drain();
    set_box(32'sh0, 32'sh0, 32'd63 << 16, 32'd63 << 16, 32'h8000_0000, 65536, 65536);
    send_particle(32'h0001_0000, 32'h0001_0000, 1'b1);
    // hold the sender until everything has come out
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 85; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 85; end
        default: begin send_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      case (ph)
        0: set_box(32'sh0, 32'sh0, 32'd63 << 16, 32'd63 << 16, 32'h0000_2000,
                   65536, 65536);
        1: set_box(-32'sd4194304, 32'sd65536, 32'sd4194304, 32'sd8388608,
                   32'hFFFF_8000, 32'h0002_0000, 32'h0001_0000);
        2: set_box(32'sh0, -32'sd1000000, 32'd100 << 16, 32'sd9000000,
                   32'h0010_0000, 32'h0000_8000, 32'h0004_0000);
        default: set_box(32'sh0, 32'sh0, 32'd63 << 16, 32'd63 << 16,
                         $urandom(), 65536, 65536);
      endcase
      case (ph)
        1: random_phase(300, 32768, 65536);
        2: random_phase(300, 131072, 16384);
        default: random_phase(300, 65536, 65536);
      endcase
      drain();
    end
    send_idle_pct = 0; sink_stall_pct = 0;
    drain();
    $display("covered %0d grid writes and %0d particles over several register settings",
             node_count, particle_count);
    $display("phases: no idling, sender idle, receiver stall, both");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/pab_pkg.sv
hw/rtl/pab_if.sv
hw/rtl/pab_cfg_if.sv
hw/rtl/pab_grid_mem.sv
hw/rtl/pab_pipe.sv
hw/rtl/particle_advect_bilinear.sv
sim/pab_advect_checker.sv
sim/tb_particle_advect_bilinear.sv
